// ===== rtl/adcss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adcss_pkg: shared types and constants for the converter readout
// Scaling constants, segment table, and the entry that links front and back.
// ----------------------------------------------------------------------------
package adcss_pkg;

  // Field widths
  localparam int unsigned SampleWidth = 10;
  localparam int unsigned ValueWidth  = 14;   // holds 0..9999
  localparam int unsigned CoefWidth   = 14;
  localparam int unsigned ProdWidth   = SampleWidth + CoefWidth;
  localparam int unsigned ScaleShift  = 12;
  localparam int unsigned ScaledWidth = ProdWidth - ScaleShift;

  // Scaling constants
  localparam logic [CoefWidth-1:0] VoltGain      = 14'd12985;
  localparam logic [CoefWidth-1:0] ThermGain     = 14'd6006;
  localparam logic signed [19:0]   ThermScale    = 20'sd100;
  localparam logic signed [19:0]   ThermOffset   = 20'sd98600;
  localparam logic signed [27:0]   ThermSlope    = 28'sd144;
  localparam int unsigned          ThermShift    = 9;
  localparam logic [ValueWidth-1:0] DisplayMax   = 14'd9999;

  // Divide by ten: q = (r * 52429) >> 19, exact for r < 2**14
  localparam logic [15:0] Recip10      = 16'd52429;
  localparam int unsigned Recip10Shift = 19;

  // Segment codes (active high before inversion)
  localparam logic [7:0] DashPattern = 8'h40;
  localparam logic [7:0] DpBit       = 8'h80;

  // Digit positions
  localparam logic [1:0] PosHundreds  = 2'd2;
  localparam logic [1:0] PosThousands = 2'd3;

  // Queue depth between front and back
  localparam int unsigned QueueDepth = 2;

  // One classified sample handed from front to back
  typedef struct packed {
    logic [ValueWidth-1:0] value;   // clamped display value
    logic                  dash;    // over range: show dashes
    logic                  therm;   // thermometer scaling in effect
  } entry_t;

  // Seven-segment pattern for one decimal digit
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/adc_to_seven_segment_readout_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adc_to_seven_segment_readout_core: converter sample to display bytes
//
//   channel   direction  handshake     payload
//   sample    in         push / full   adc_sample_i
//   display   out        empty / pop   segment_byte_o, digit_position_o,
//                                      last_byte_o
//   config    in         cfg_we_i      cfg_wdata_i (thermometer mode)
//
// Samples pass through the registered scaling front and the queue; the back
// part then emits one byte per cycle while the display side keeps popping,
// units first, and the digit sequencer takes the next sample only after the
// thousands byte of the last. Reset clears all control state and sets
// thermometer mode; no clearing pass. A stalled display side fills the queue and then raises full.
// ----------------------------------------------------------------------------
module adc_to_seven_segment_readout_core #(
  parameter int unsigned QueueDepth = adcss_pkg::QueueDepth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_wdata_i,
  input  wire logic                               push,
  output      logic                               full,
  input  wire logic [adcss_pkg::SampleWidth-1:0]  adc_sample_i,
  output      logic                               empty,
  input  wire logic                               pop,
  output      logic [7:0]                         segment_byte_o,
  output      logic [1:0]                         digit_position_o,
  output      logic                               last_byte_o
);

  logic               therm_q;
  logic               front_ready;
  logic               front_valid;
  adcss_pkg::entry_t  front_entry;
  logic               q_full, q_empty, q_pop;
  adcss_pkg::entry_t  q_head;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      therm_q <= 1'b1;
    end else if (cfg_we_i) begin
      therm_q <= cfg_wdata_i;
    end
  end

  assign full = !front_ready;

  // Scaling front
  adcss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .therm_i     (therm_q),
    .in_valid_i  (push),
    .in_ready_o  (front_ready),
    .sample_i    (adc_sample_i),
    .out_valid_o (front_valid),
    .out_ready_i (!q_full),
    .out_entry_o (front_entry)
  );

  // Decoupling queue
  adcss_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (front_valid),
    .push_entry_i (front_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .head_o       (q_head)
  );

  // Digit sequencer
  adcss_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_head_i         (q_head),
    .q_pop_o          (q_pop),
    .empty_o          (empty),
    .pop_i            (pop),
    .segment_byte_o   (segment_byte_o),
    .digit_position_o (digit_position_o),
    .last_byte_o      (last_byte_o)
  );

`ifndef SYNTHESIS
  // The last flag only ever rides on the thousands byte
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_byte_o) |-> (digit_position_o == adcss_pkg::PosThousands))
    else $error("last byte not on thousands position");

  // Bytes of one sample follow without a gap, position counting up
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_byte_o) |=>
      (!empty && (digit_position_o == $past(digit_position_o) + 2'd1)))
    else $error("digit sequence broken");

  // A full queue means the back side is holding a result
  a_full_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !empty)
    else $error("queue full while display side idle");
`endif

endmodule
`default_nettype wire

// ===== rtl/adcss_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adcss_front: sample scaling and range classification
// Two register stages scale the sample, a third step clamps and classifies.
// ----------------------------------------------------------------------------
module adcss_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                therm_i,
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic [adcss_pkg::SampleWidth-1:0]   sample_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      adcss_pkg::entry_t                   out_entry_o
);

  logic                                 advance;
  logic                                 valid1_q, valid2_q;
  logic                                 therm1_q, therm2_q;
  logic [adcss_pkg::ProdWidth-1:0]      prod_q, prod_d;
  logic [adcss_pkg::CoefWidth-1:0]      coef;
  logic [adcss_pkg::ScaledWidth-1:0]    scaled;
  logic signed [19:0]                   scaled_s;
  logic signed [19:0]                   lin_q, lin_d;
  logic signed [27:0]                   slope_prod;
  logic signed [19:0]                   val;
  logic                                 neg, over;

  // Pipeline moves unless the last stage holds a request the queue refuses
  assign advance    = !(valid2_q && !out_ready_i);
  assign in_ready_o = advance;

  // Stage 1: gain multiply
  assign coef   = therm_i ? adcss_pkg::ThermGain : adcss_pkg::VoltGain;
  assign prod_d = {{adcss_pkg::CoefWidth{1'b0}}, sample_i}
                * {{adcss_pkg::SampleWidth{1'b0}}, coef};

  // Stage 2: offset and scale of the thermometer path
  assign scaled   = prod_q[adcss_pkg::ProdWidth-1:adcss_pkg::ScaleShift];
  assign scaled_s = $signed({8'b0, scaled});
  assign lin_d    = therm1_q ? (scaled_s * adcss_pkg::ThermScale - adcss_pkg::ThermOffset)
                             : scaled_s;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (advance) begin
      valid1_q <= in_valid_i;
      valid2_q <= valid1_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (advance) begin
      prod_q   <= prod_d;
      therm1_q <= therm_i;
      lin_q    <= lin_d;
      therm2_q <= therm1_q;
    end
  end

  // Stage 3: slope, floor shift, clamp and classify
  assign slope_prod = $signed({{8{lin_q[19]}}, lin_q}) * adcss_pkg::ThermSlope;
  assign val  = therm2_q ? {slope_prod[27], slope_prod[27:adcss_pkg::ThermShift]} : lin_q;
  assign neg  = val[19];
  assign over = !neg && (val[18:0] > 19'(adcss_pkg::DisplayMax));

  assign out_valid_o       = valid2_q;
  assign out_entry_o.value = (neg || over) ? '0 : val[adcss_pkg::ValueWidth-1:0];
  assign out_entry_o.dash  = over;
  assign out_entry_o.therm = therm2_q;

endmodule
`default_nettype wire

// ===== rtl/adcss_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adcss_queue: small register queue between front and back
// First-in first-out, head shown combinationally.
// ----------------------------------------------------------------------------
module adcss_queue #(
  parameter int unsigned Depth = adcss_pkg::QueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire adcss_pkg::entry_t  push_entry_i,
  output      logic               full_o,
  input  wire logic               pop_i,
  output      logic               empty_o,
  output      adcss_pkg::entry_t  head_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);

  adcss_pkg::entry_t      entries_q [Depth];
  logic [PtrWidth-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0]    count_q;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == CntWidth'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entries_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/adcss_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adcss_back: digit sequencer and output register
// Peels one decimal digit per cycle unless stalled, units first, into seg_q.
// ----------------------------------------------------------------------------
module adcss_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire adcss_pkg::entry_t  q_head_i,
  output      logic               q_pop_o,
  output      logic               empty_o,
  input  wire logic               pop_i,
  output      logic [7:0]         segment_byte_o,
  output      logic [1:0]         digit_position_o,
  output      logic               last_byte_o
);

  localparam int unsigned VW = adcss_pkg::ValueWidth;

  logic                 busy_q;
  logic [1:0]           cnt_q;
  logic [VW-1:0]        rem_q;
  logic                 dash_q, therm_q;
  logic                 ovalid_q;
  logic [7:0]           seg_q;
  logic [1:0]           pos_q;
  logic                 last_q;

  logic                 out_free, step;
  logic [VW-1:0]        src_val;
  logic                 src_dash, src_therm;
  logic [1:0]           src_pos;
  logic [VW+15:0]       recip_prod;
  logic [VW-1:0]        quot;
  logic [VW-1:0]        rem10;
  logic [3:0]           digit;
  logic                 dp;
  logic [7:0]           pat;

  // Work on the running value, or start straight from the queue head
  assign out_free  = !ovalid_q || pop_i;
  assign step      = out_free && (busy_q || !q_empty_i);
  assign q_pop_o   = out_free && !busy_q && !q_empty_i;
  assign src_val   = busy_q ? rem_q   : q_head_i.value;
  assign src_dash  = busy_q ? dash_q  : q_head_i.dash;
  assign src_therm = busy_q ? therm_q : q_head_i.therm;
  assign src_pos   = busy_q ? cnt_q   : 2'd0;

  // Divide by ten through the reciprocal
  assign recip_prod = {16'b0, src_val} * {{VW{1'b0}}, adcss_pkg::Recip10};
  assign quot  = VW'(recip_prod >> adcss_pkg::Recip10Shift);
  assign rem10 = src_val - ((quot << 3) + (quot << 1));
  assign digit = rem10[3:0];

  // Pattern with decimal point
  assign dp  = src_therm ? (src_pos == adcss_pkg::PosHundreds)
                         : (src_pos == adcss_pkg::PosThousands);
  assign pat = (src_dash ? adcss_pkg::DashPattern : adcss_pkg::seg_pattern(digit))
             | (dp ? adcss_pkg::DpBit : 8'h00);

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else if (step) begin
      busy_q   <= (src_pos != adcss_pkg::PosThousands);
      cnt_q    <= src_pos + 2'd1;
      ovalid_q <= 1'b1;
    end else if (pop_i) begin
      ovalid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      rem_q   <= quot;
      dash_q  <= src_dash;
      therm_q <= src_therm;
      seg_q   <= ~pat;
      pos_q   <= src_pos;
      last_q  <= (src_pos == adcss_pkg::PosThousands);
    end
  end

  assign empty_o          = !ovalid_q;
  assign segment_byte_o   = seg_q;
  assign digit_position_o = pos_q;
  assign last_byte_o      = last_q;

endmodule
`default_nettype wire
